/* hw/rtl/mbrf_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte update for the request framer.
package mbrf_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned PosW       = $clog2(FrameBytes);

  localparam logic [15:0]     CrcInit = 16'hFFFF;
  localparam logic [15:0]     CrcPoly = 16'hA001;
  localparam logic [PosW-1:0] LastPos = PosW'(FrameBytes - 1);

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] register_value;
  } req_t;

  typedef struct packed {
    logic [7:0]      frame_byte;
    logic [PosW-1:0] byte_position;
    logic            last_byte;
  } word_t;

  typedef struct packed {
    req_t        req;
    logic [15:0] crc;
  } stage_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

/* hw/rtl/mbrf_crc_stage.sv */
// One pipeline stage that folds two frame bytes into the running CRC.
module mbrf_crc_stage
  import mbrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  stage_t     data_i,
  input  logic [7:0] byte_a_i,
  input  logic [7:0] byte_b_i,
  output logic       valid_o,
  input  logic       stall_i,
  output stage_t     data_o
);

  logic   valid_q;
  stage_t data_q, data_d;
  logic   load;

  assign stall_o = valid_q & stall_i;
  assign load    = valid_i & ~stall_o;

  always_comb begin
    data_d     = data_i;
    data_d.crc = crc_byte(crc_byte(data_i.crc, byte_a_i), byte_b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/mbrf_serializer.sv */
// Frame register that sends the eight bytes of one request, one word per cycle while out_stall_i is low.
module mbrf_serializer
  import mbrf_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   stall_o,
  input  stage_t data_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output word_t  out_word_o
);

  logic [FrameBytes-1:0][7:0] frame_q, frame_d;
  logic [PosW-1:0]            cnt_q;
  logic                       valid_q;
  logic                       load, send, done;

  assign send    = valid_q & ~out_stall_i;
  assign done    = send & (cnt_q == LastPos);
  assign stall_o = valid_q & ~done;
  assign load    = valid_i & ~stall_o;

  always_comb begin
    frame_d[0] = data_i.req.slave_address;
    frame_d[1] = data_i.req.function_code;
    frame_d[2] = data_i.req.register_address[15:8];
    frame_d[3] = data_i.req.register_address[7:0];
    frame_d[4] = data_i.req.register_value[15:8];
    frame_d[5] = data_i.req.register_value[7:0];
    frame_d[6] = data_i.crc[7:0];
    frame_d[7] = data_i.crc[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      priority if (load) begin
        valid_q <= 1'b1;
        cnt_q   <= '0;
      end else if (done) begin
        valid_q <= 1'b0;
        cnt_q   <= '0;
      end else if (send) begin
        cnt_q <= cnt_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_d;
    end
  end

  assign out_valid_o              = valid_q;
  assign out_word_o.frame_byte    = frame_q[cnt_q];
  assign out_word_o.byte_position = cnt_q;
  assign out_word_o.last_byte     = (cnt_q == LastPos);

endmodule

/* hw/rtl/modbus_rtu_request_framer.sv */
// Top level of the Modbus RTU request framer: CRC pipeline and frame serializer.
//
// A request word enters on in_word_i when in_valid_i is high and in_stall_o
// is low. Three pipeline stages each fold two frame bytes into the
// CRC-16/MODBUS check (reflected polynomial 0xA001, start value 0xFFFF).
// The finished frame is then loaded into the serializer, which sends eight
// output words, one per cycle: address, function, register address high and
// low, value high and low, then the check low and high byte. The last word
// of a frame has last_byte set.
// A request passes the three CRC stage registers, then the serializer loads it.
// The serializer takes a new request only when idle or when it sends the last
// word of the previous one; the pipeline holds up to three further requests,
// and a new frame follows the previous one without a gap.
// When the receiver raises out_stall_i, the current word holds and the
// stall travels back through the pipeline stages to in_stall_o.
// Reset clears all valid bits and the byte counter; no word is then pending.
module modbus_rtu_request_framer
  import mbrf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  req_t  in_word_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output word_t out_word_o
);

  stage_t s0_data, s1_data, s2_data, s3_data;
  logic   s1_valid, s2_valid, s3_valid;
  logic   s1_stall, s2_stall, s3_stall;

  always_comb begin
    s0_data.req = in_word_i;
    s0_data.crc = CrcInit;
  end

  mbrf_crc_stage u_stage1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .stall_o  (in_stall_o),
    .data_i   (s0_data),
    .byte_a_i (s0_data.req.slave_address),
    .byte_b_i (s0_data.req.function_code),
    .valid_o  (s1_valid),
    .stall_i  (s1_stall),
    .data_o   (s1_data)
  );

  mbrf_crc_stage u_stage2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .stall_o  (s1_stall),
    .data_i   (s1_data),
    .byte_a_i (s1_data.req.register_address[15:8]),
    .byte_b_i (s1_data.req.register_address[7:0]),
    .valid_o  (s2_valid),
    .stall_i  (s2_stall),
    .data_o   (s2_data)
  );

  mbrf_crc_stage u_stage3 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .stall_o  (s2_stall),
    .data_i   (s2_data),
    .byte_a_i (s2_data.req.register_value[15:8]),
    .byte_b_i (s2_data.req.register_value[7:0]),
    .valid_o  (s3_valid),
    .stall_i  (s3_stall),
    .data_o   (s3_data)
  );

  mbrf_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s3_valid),
    .stall_o     (s3_stall),
    .data_i      (s3_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* hw/rtl/mbrf_checker.sv */
// Port-level assertions for the request framer and the bind that attaches them.
module mbrf_checker
  import mbrf_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_stall_o,
  input req_t  in_word_i,
  input logic  out_valid_o,
  input logic  out_stall_i,
  input word_t out_word_o
);

  logic out_acc;
  assign out_acc = out_valid_o & ~out_stall_i;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("Stalled input word changed.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("Stalled output word changed.");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_word_o.last_byte |=> out_valid_o)
    else $error("Frame broke off before its last word.");

  a_position_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !out_valid_o || (out_word_o.byte_position ==
      $past(out_word_o.byte_position) + PosW'(1)))
    else $error("Byte position did not advance by one.");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.last_byte == (out_word_o.byte_position == LastPos))
    else $error("Last-byte flag does not match the byte position.");

endmodule

bind modbus_rtu_request_framer mbrf_checker u_mbrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

/* tb/sv/modbus_rtu_request_framer_tb.sv */
// Testbench for the Modbus RTU request framer: directed table, random requests, CRC predictor.
module modbus_rtu_request_framer_tb;
  import mbrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldLen    = 80;
  localparam int unsigned RandomReqs = 204;
  localparam int unsigned TailCycles = 20;

  typedef struct packed {
    req_t        req;
    logic        known;
    logic [63:0] frame;
  } dir_row_t;

  localparam int unsigned DirRows = 14;
  localparam dir_row_t DirTbl [DirRows] = '{
    '{req: '{8'h01, 8'h03, 16'h0000, 16'h0001}, known: 1'b1, frame: 64'h01030000_0001840A},
    '{req: '{8'h01, 8'h03, 16'h0000, 16'h000A}, known: 1'b1, frame: 64'h01030000_000AC5CD},
    '{req: '{8'h11, 8'h03, 16'h006B, 16'h0003}, known: 1'b1, frame: 64'h1103006B_00037687},
    '{req: '{8'h00, 8'h00, 16'h0000, 16'h0000}, known: 1'b0, frame: 64'h0},
    '{req: '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF}, known: 1'b0, frame: 64'h0},
    '{req: '{8'h00, 8'hFF, 16'h0000, 16'hFFFF}, known: 1'b0, frame: 64'h0},
    '{req: '{8'hFF, 8'h00, 16'hFFFF, 16'h0000}, known: 1'b0, frame: 64'h0},
    '{req: '{8'h01, 8'h06, 16'h0001, 16'h0003}, known: 1'b0, frame: 64'h0},
    '{req: '{8'hAA, 8'h55, 16'hAAAA, 16'h5555}, known: 1'b0, frame: 64'h0},
    '{req: '{8'h55, 8'hAA, 16'h5555, 16'hAAAA}, known: 1'b0, frame: 64'h0},
    '{req: '{8'hF7, 8'h10, 16'h8000, 16'h0001}, known: 1'b0, frame: 64'h0},
    '{req: '{8'h80, 8'h01, 16'h7FFF, 16'h8000}, known: 1'b0, frame: 64'h0},
    '{req: '{8'h01, 8'h7F, 16'h0100, 16'h00FF}, known: 1'b0, frame: 64'h0},
    '{req: '{8'hFE, 8'h80, 16'h00FF, 16'hFF00}, known: 1'b0, frame: 64'h0}
  };

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  req_t  in_word;
  logic  out_valid;
  logic  out_stall;
  word_t out_word;

  word_t frame_words_q [$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          hold_req;

  modbus_rtu_request_framer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [15:0] modbus_crc(input logic [47:0] head);
    logic [15:0] acc;
    logic [7:0]  b;
    acc = CrcInit;
    for (int i = 0; i < 6; i++) begin
      b = head[47 - 8 * i -: 8];
      for (int j = 0; j < 8; j++) begin
        if (acc[0] ^ b[j]) begin
          acc = (acc >> 1) ^ CrcPoly;
        end else begin
          acc = acc >> 1;
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] frame_of(input req_t r);
    logic [47:0] head;
    logic [15:0] crc;
    head = {r.slave_address, r.function_code, r.register_address, r.register_value};
    crc  = modbus_crc(head);
    return {head, crc[7:0], crc[15:8]};
  endfunction

  function automatic void queue_frame(input logic [63:0] frame);
    word_t w;
    for (int k = 0; k < FrameBytes; k++) begin
      w.frame_byte    = frame[63 - 8 * k -: 8];
      w.byte_position = PosW'(k);
      w.last_byte     = (PosW'(k) == LastPos);
      frame_words_q.push_back(w);
    end
  endfunction

  function automatic logic [15:0] pick16();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) begin
      return 16'h0000;
    end else if (sel == 1) begin
      return 16'hFFFF;
    end
    return 16'($urandom);
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.slave_address    = 8'(pick16());
    r.function_code    = ($urandom_range(1) == 0) ? 8'($urandom_range(6) + 1) : 8'(pick16());
    r.register_address = pick16();
    r.register_value   = pick16();
    return r;
  endfunction

  task automatic send_req(input req_t r, input logic [63:0] frame);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= r;
    do @(posedge clk); while (in_stall);
    queue_frame(frame);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (frame_words_q.size() != 0);
  endtask

  initial begin : receiver
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        held++;
        if (held >= HoldLen) begin
          held     = 0;
          hold_req = 1'b0;
        end
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_words_q.size() == 0) begin
        $error("unexpected word: frame_byte %02h byte_position %0d last_byte %0b",
               out_word.frame_byte, out_word.byte_position, out_word.last_byte);
        fail_count++;
      end else begin
        exp_w = frame_words_q.pop_front();
        if (out_word.frame_byte !== exp_w.frame_byte) begin
          $error("frame_byte: expected %02h, actual %02h", exp_w.frame_byte, out_word.frame_byte);
          fail_count++;
        end
        if (out_word.byte_position !== exp_w.byte_position) begin
          $error("byte_position: expected %0d, actual %0d",
                 exp_w.byte_position, out_word.byte_position);
          fail_count++;
        end
        if (out_word.last_byte !== exp_w.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", exp_w.last_byte, out_word.last_byte);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_word            = '0;
    out_stall          = 1'b0;
    fail_count         = 0;
    hold_req           = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      send_req(DirTbl[i].req, DirTbl[i].known ? DirTbl[i].frame : frame_of(DirTbl[i].req));
    end

    // The receiver holds off while requests keep coming, so the input stalls.
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      r = random_req();
      send_req(r, frame_of(r));
    end
    drain();

    for (int i = 0; i < RandomReqs; i++) begin
      case (i / 46)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 56;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 56;
        end
        3: begin
          sender_idle_pct    = 16;
          receiver_stall_pct = 16;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      r = random_req();
      send_req(r, frame_of(r));
    end

    drain();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
